FILE: rtl/j5s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// j5s_pkg: shared types and constants of the Jacobi 5-point stencil unit
// Widths, register indexes, the reciprocal used for the divide by five and
// the structs that pass between the scan control, line stores and averager.
// ----------------------------------------------------------------------------
package j5s_pkg;

    localparam int MAX_GRID    = 1024;
    localparam int COL_W       = $clog2(MAX_GRID);
    localparam int GRID_W      = 11;
    localparam int BORDER_W    = 9;
    localparam int DATA_W      = 16;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    // five 16-bit cells plus the rounding constant fit in 19 bits
    localparam int SUM_W       = DATA_W + 3;
    // floor(x / 5) == (x * RECIP_FIVE) >> RECIP_SHIFT for every x below 2**19
    localparam int RECIP_SHIFT = 21;
    localparam int RECIP_W     = 19;
    localparam logic [RECIP_W-1:0] RECIP_FIVE = 19'd419431;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [SUM_W-1:0] ROUND_HALF = 19'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_SIZE    = 1'b0,
        REG_BORDER_WIDTH = 1'b1
    } cfg_reg_e_t;

    // position of the cell being accepted and what it triggers
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] col_right;
        logic             emit;
        logic             last;
    } scan_pos_t;

    // five cells of one stencil plus the end-of-frame flag
    typedef struct packed {
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] centre;
        logic [DATA_W-1:0] right;
        logic [DATA_W-1:0] up;
        logic [DATA_W-1:0] down;
        logic              last;
    } stencil_t;

endpackage

FILE: rtl/j5s_scan_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// j5s_scan_ctrl: configuration registers and raster position counters
// Tracks row and column of the next cell, flags cells whose upper neighbour
// is an interior cell and marks the cell below the last interior cell of the frame.
// ----------------------------------------------------------------------------
module j5s_scan_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [j5s_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [j5s_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             accept,
    output j5s_pkg::scan_pos_t               pos
);
    import j5s_pkg::*;

    logic [GRID_W-1:0]   grid_reg, grid_next;
    logic [BORDER_W-1:0] border_reg, border_next;
    logic [COL_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;

    logic [GRID_W-1:0]   g_eff;
    logic [BORDER_W-1:0] b_eff;
    logic [GRID_W-1:0]   b_ext;
    logic [GRID_W-1:0]   twice_b;
    logic [GRID_W-1:0]   hi;
    logic [GRID_W-1:0]   col_ext;
    logic [GRID_W-1:0]   row_ext;
    logic [GRID_W-1:0]   col_inc;
    logic [GRID_W-1:0]   row_inc;
    logic                has_int;
    logic                col_in;
    logic                row_in;

    always_comb
    begin
        g_eff = grid_reg;
        if (grid_reg == '0)
        begin
            g_eff = GRID_W'(1);
        end
        else if (grid_reg > GRID_W'(MAX_GRID))
        begin
            g_eff = GRID_W'(MAX_GRID);
        end
        b_eff   = (border_reg == '0) ? BORDER_W'(1) : border_reg;
        b_ext   = {{(GRID_W-BORDER_W){1'b0}}, b_eff};
        twice_b = {{(GRID_W-BORDER_W-1){1'b0}}, b_eff, 1'b0};
        has_int = twice_b < g_eff;
        hi      = g_eff - b_ext;
        col_ext = {{(GRID_W-COL_W){1'b0}}, col_reg};
        row_ext = {{(GRID_W-COL_W){1'b0}}, row_reg};
        col_inc = col_ext + GRID_W'(1);
        row_inc = row_ext + GRID_W'(1);

        // the cell arriving now is the lower neighbour of row - 1
        col_in = (col_ext >= b_ext) && (col_ext < hi);
        row_in = (row_ext > b_ext) && (row_ext <= hi);

        pos.col       = col_reg;
        pos.col_right = col_inc[COL_W-1:0];
        pos.emit      = has_int && col_in && row_in;
        pos.last      = (row_ext == hi) && (col_inc == hi);
    end

    always_comb
    begin
        grid_next   = grid_reg;
        border_next = border_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        if (cfg_write)
        begin
            case (cfg_reg_e_t'(cfg_index))
                REG_GRID_SIZE:    grid_next   = cfg_data[GRID_W-1:0];
                REG_BORDER_WIDTH: border_next = cfg_data[BORDER_W-1:0];
                default:          ;
            endcase
            // restart the frame
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (col_inc >= g_eff)
            begin
                col_next = '0;
                row_next = (row_inc >= g_eff) ? '0 : row_inc[COL_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg   <= GRID_W'(MAX_GRID);
            border_reg <= BORDER_W'(1);
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else
        begin
            grid_reg   <= grid_next;
            border_reg <= border_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
        end
    end

endmodule

FILE: rtl/j5s_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// j5s_line_store: the two row memories and the stencil gather stage
// Reads the middle row at the column and the one to its right, the upper
// row at the column, and writes the new cell back in the same cycle.
// ----------------------------------------------------------------------------
module j5s_line_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  j5s_pkg::scan_pos_t            pos,
    input  logic [j5s_pkg::DATA_W-1:0]    cell_value,
    output logic                          gather_ready,
    output logic                          sten_valid,
    input  logic                          sten_ready,
    output j5s_pkg::stencil_t             sten
);
    import j5s_pkg::*;

    logic [DATA_W-1:0] middle_mem [MAX_GRID];
    logic [DATA_W-1:0] upper_mem  [MAX_GRID];

    logic              s1_valid_reg, s1_valid_next;
    logic [COL_W-1:0]  s1_col_reg;
    logic              s1_emit_reg;
    logic              s1_last_reg;
    logic [DATA_W-1:0] s1_down_reg;
    logic [DATA_W-1:0] centre_rd_reg;
    logic [DATA_W-1:0] right_rd_reg;
    logic [DATA_W-1:0] up_rd_reg;
    logic [DATA_W-1:0] left_reg, left_next;
    logic              s1_advance;

    // a stage that emits nothing drains without waiting for the averager
    assign gather_ready = !s1_valid_reg || !s1_emit_reg || sten_ready;
    assign s1_advance   = s1_valid_reg && gather_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        left_next     = left_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        // slide the window: this centre is the next cell's left neighbour
        if (s1_advance)
        begin
            left_next = centre_rd_reg;
        end
    end

    // read first: the reads see the row as it was before this cell
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            centre_rd_reg        <= middle_mem[pos.col];
            right_rd_reg         <= middle_mem[pos.col_right];
            up_rd_reg            <= upper_mem[pos.col];
            middle_mem[pos.col]  <= cell_value;
            s1_col_reg           <= pos.col;
            s1_emit_reg          <= pos.emit;
            s1_last_reg          <= pos.last;
            s1_down_reg          <= cell_value;
        end
        // push the old middle value down into the upper row
        if (s1_advance)
        begin
            upper_mem[s1_col_reg] <= centre_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            left_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            left_reg     <= left_next;
        end
    end

    assign sten_valid  = s1_valid_reg && s1_emit_reg;
    assign sten.left   = left_reg;
    assign sten.centre = centre_rd_reg;
    assign sten.right  = right_rd_reg;
    assign sten.up     = up_rd_reg;
    assign sten.down   = s1_down_reg;
    assign sten.last   = s1_last_reg;

endmodule

FILE: rtl/j5s_avg_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// j5s_avg_pipe: rounded average of five cells
// Stage one sums the cells with the rounding offset, stage two multiplies by
// the reciprocal of five into the output register.
// ----------------------------------------------------------------------------
module j5s_avg_pipe (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sten_valid,
    output logic                          sten_ready,
    input  j5s_pkg::stencil_t             sten,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [j5s_pkg::DATA_W-1:0]    new_value,
    output logic                          last_cell
);
    import j5s_pkg::*;

    logic              s2_valid_reg, s2_valid_next;
    logic [SUM_W-1:0]  s2_sum_reg;
    logic              s2_last_reg;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_last_reg;
    logic              out_en;
    logic              s2_en;
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;

    assign out_en     = !out_valid_reg || !result_stall;
    assign s2_en      = !s2_valid_reg || out_en;
    assign sten_ready = s2_en;

    always_comb
    begin
        sum = SUM_W'(sten.left) + SUM_W'(sten.centre) + SUM_W'(sten.right)
            + SUM_W'(sten.up) + SUM_W'(sten.down) + ROUND_HALF;
        prod = PROD_W'(s2_sum_reg) * PROD_W'(RECIP_FIVE);

        s2_valid_next  = s2_valid_reg;
        out_valid_next = out_valid_reg;
        if (s2_en)
        begin
            s2_valid_next = sten_valid;
        end
        if (out_en)
        begin
            out_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && sten_valid)
        begin
            s2_sum_reg  <= sum;
            s2_last_reg <= sten.last;
        end
        if (out_en && s2_valid_reg)
        begin
            out_value_reg <= prod[RECIP_SHIFT +: DATA_W];
            out_last_reg  <= s2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign new_value    = out_value_reg;
    assign last_cell    = out_last_reg;

endmodule

FILE: rtl/jacobi_5point_stencil_unit.sv
`timescale 1ns / 1ps
// Pipeline: the request carrying the cell below a result is registered in the
//   gather stage, then in the sum stage, then in the output register.
// Throughput: one cell per cycle while cell_stall is low, set by the
//   middle-row memory taking one write and two reads in every cycle.
// Reset: position counters clear, grid_size returns to 1024 and border_width
//   to 1; the line stores keep their contents and need no clearing pass.
// ----------------------------------------------------------------------------
// jacobi_5point_stencil_unit: one Jacobi sweep over a streamed square grid
// Interior cells become the rounded average of themselves and their four
// neighbours; border cells are consumed and never emitted.
// ----------------------------------------------------------------------------
module jacobi_5point_stencil_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [j5s_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [j5s_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             cell_valid,
    output logic                             cell_stall,
    input  logic [j5s_pkg::DATA_W-1:0]       cell_value,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [j5s_pkg::DATA_W-1:0]       new_value,
    output logic                             last_cell
);
    import j5s_pkg::*;

    scan_pos_t pos;
    stencil_t  sten;
    logic      gather_ready;
    logic      sten_valid;
    logic      sten_ready;
    logic      accept;

    assign cell_stall = !gather_ready;
    assign accept     = cell_valid && gather_ready;

    j5s_scan_ctrl u_scan_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pos       (pos)
    );

    j5s_line_store u_line_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .pos          (pos),
        .cell_value   (cell_value),
        .gather_ready (gather_ready),
        .sten_valid   (sten_valid),
        .sten_ready   (sten_ready),
        .sten         (sten)
    );

    j5s_avg_pipe u_avg_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .sten_valid   (sten_valid),
        .sten_ready   (sten_ready),
        .sten         (sten),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .new_value    (new_value),
        .last_cell    (last_cell)
    );

endmodule

FILE: rtl/j5s_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// j5s_checker: port-level checks of the stencil unit
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module j5s_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cell_valid,
    input  logic                          cell_stall,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic [j5s_pkg::DATA_W-1:0]    new_value,
    input  logic                          last_cell
);
    import j5s_pkg::*;

    // hold a stalled result
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(new_value) && $stable(last_cell))
        else $error("stalled result payload changed");

    // with the output register empty the whole pipeline can advance
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !cell_stall)
        else $error("input stalled with empty output");

    // a stalled request means the output side is blocked
    a_stall_needs_blocked_output: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && cell_stall |-> result_valid && result_stall)
        else $error("request stalled while the result channel moves");

endmodule

bind jacobi_5point_stencil_unit j5s_checker u_j5s_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .new_value    (new_value),
    .last_cell    (last_cell)
);

FILE: bench/jacobi_5point_stencil_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobi_5point_stencil_unit_tb: self-checking bench for the stencil unit
// Streams grids in raster order under several grid and border settings.
// Idle and stall patterns vary between phases. A local line-store model
// predicts each interior average. Every result is compared in order.
// ----------------------------------------------------------------------------
module jacobi_5point_stencil_unit_tb;

    import j5s_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } average_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   cell_valid = 1'b0;
    logic                   cell_stall;
    logic [DATA_W-1:0]      cell_value = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic [DATA_W-1:0]      new_value;
    logic                   last_cell;

    // predictor state
    logic [DATA_W-1:0]   upper_store [MAX_GRID];
    logic [DATA_W-1:0]   middle_store [MAX_GRID];
    logic [DATA_W-1:0]   prev_centre = '0;
    logic [GRID_W-1:0]   grid_reg = 11'd1024;
    logic [BORDER_W-1:0] border_reg = 9'd1;
    int                  row_pos = 0;
    int                  col_pos = 0;

    average_t pending_averages [$];
    average_t oldest_average;
    average_t next_average;
    int       error_count = 0;
    int       cells_sent = 0;
    int       send_idle_pct = 0;
    int       stall_pct = 0;
    int       hold_off_cycles = 0;

    jacobi_5point_stencil_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_value   (cell_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .new_value    (new_value),
        .last_cell    (last_cell)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int eff_grid();
        if (grid_reg == 0)
            return 1;
        if (grid_reg > MAX_GRID)
            return MAX_GRID;
        return int'(grid_reg);
    endfunction

    function automatic int eff_border();
        return (border_reg == 0) ? 1 : int'(border_reg);
    endfunction

    function automatic bit interior(input int pos, input int g, input int b);
        return (2 * b < g) && (pos >= b) && (pos < g - b);
    endfunction

    // advance the line stores by one cell; returns 1 when an average is due
    function automatic bit predict_average(input logic [DATA_W-1:0] down,
                                           output average_t res);
        int                g;
        int                b;
        int                r;
        int                c;
        logic [DATA_W-1:0] centre;
        logic [DATA_W-1:0] right;
        logic [DATA_W-1:0] up;
        logic [DATA_W-1:0] left;
        logic [SUM_W-1:0]  sum;
        bit                emit;
        g = eff_grid();
        b = eff_border();
        r = row_pos;
        c = col_pos;
        centre = middle_store[c];
        up = upper_store[c];
        right = (c + 1 < MAX_GRID) ? middle_store[c + 1] : '0;
        // the store already holds the new row at c-1, so keep the old one here
        left = prev_centre;
        prev_centre = centre;
        emit = (r >= 1) && interior(r - 1, g, b) && interior(c, g, b);
        sum = SUM_W'(left) + SUM_W'(centre) + SUM_W'(right) + SUM_W'(up) + SUM_W'(down);
        res.value = DATA_W'((sum + SUM_W'(2)) / SUM_W'(5));
        res.last = emit && (r - 1 == g - b - 1) && (c == g - b - 1);
        upper_store[c] = centre;
        middle_store[c] = down;
        if (c + 1 >= g)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= g) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
        return emit;
    endfunction

    // check the result first: a request accepted on this edge cannot cause it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_averages.size() == 0)
                begin
                    $error("unexpected result: new_value %0d last_cell %0b",
                           new_value, last_cell);
                    error_count++;
                end
                else
                begin
                    oldest_average = pending_averages.pop_front();
                    if (new_value !== oldest_average.value)
                    begin
                        $error("new_value: expected %0d, got %0d",
                               oldest_average.value, new_value);
                        error_count++;
                    end
                    if (last_cell !== oldest_average.last)
                    begin
                        $error("last_cell: expected %0b, got %0b",
                               oldest_average.last, last_cell);
                        error_count++;
                    end
                end
            end
            if (cell_valid && !cell_stall)
            begin
                if (predict_average(cell_value, next_average))
                    pending_averages = {pending_averages, next_average};
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            result_stall <= 1'b1;
            hold_off_cycles = hold_off_cycles - 1;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_cell(input logic [DATA_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            cell_valid <= 1'b0;
        end
        @(negedge clk);
        cell_valid <= 1'b1;
        cell_value <= v;
        @(posedge clk);
        while (cell_stall)
            @(posedge clk);
        cells_sent++;
    endtask

    function automatic logic [DATA_W-1:0] random_cell();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return 16'hFFFF;
        if (pick == 1)
            return 16'h0000;
        return DATA_W'($urandom);
    endfunction

    task automatic stream_cells(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_cell(random_cell());
    endtask

    // drop the request line and wait until the unit has drained
    task automatic settle();
        @(negedge clk);
        cell_valid <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_e_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_GRID_SIZE)
            grid_reg = val;
        else
            border_reg = val[BORDER_W-1:0];
        // any write restarts the frame
        row_pos = 0;
        col_pos = 0;
    endtask

    // a full-width row and the start of the next under the reset settings
    task automatic test_default_grid();
        stream_cells(MAX_GRID + 8);
        settle();
    endtask

    task automatic test_smallest_grid();
        write_register(REG_GRID_SIZE, 11'd3);
        write_register(REG_BORDER_WIDTH, 11'd1);
        repeat (9) send_cell(16'hFFFF);
        send_cell(16'h0000);
        send_cell(16'hAAAA);
        send_cell(16'h0000);
        send_cell(16'h5555);
        send_cell(16'h0001);
        send_cell(16'h8000);
        send_cell(16'h0000);
        send_cell(16'hFFFF);
        send_cell(16'h0000);
        settle();
        // zero border behaves as one
        write_register(REG_BORDER_WIDTH, 11'd0);
        stream_cells(9);
        settle();
    endtask

    task automatic test_no_interior();
        write_register(REG_GRID_SIZE, 11'd0);
        stream_cells(2);
        settle();
        write_register(REG_GRID_SIZE, 11'd2);
        stream_cells(3);
        settle();
        write_register(REG_GRID_SIZE, 11'd9);
        write_register(REG_BORDER_WIDTH, 11'd511);
        stream_cells(6);
        settle();
        // oversized grid clamps to the maximum
        write_register(REG_GRID_SIZE, 11'd2047);
        stream_cells(3);
        settle();
        // border exactly half the grid leaves no interior
        write_register(REG_GRID_SIZE, 11'd4);
        write_register(REG_BORDER_WIDTH, 11'd2);
        stream_cells(16);
        settle();
    endtask

    task automatic test_restart_midframe();
        write_register(REG_GRID_SIZE, 11'd5);
        write_register(REG_BORDER_WIDTH, 11'd1);
        stream_cells(13);
        settle();
        write_register(REG_BORDER_WIDTH, 11'd1);
        stream_cells(25);
        // second frame right behind, no write in between
        stream_cells(25);
        settle();
    endtask

    // hold results off long enough to back up the input side
    task automatic test_result_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        write_register(REG_GRID_SIZE, 11'd16);
        write_register(REG_BORDER_WIDTH, 11'd1);
        @(posedge clk);
        hold_off_cycles = 150;
        stream_cells(256);
        settle();
    endtask

    task automatic test_random_frames(input int idle_pct, input int stall_level,
                                      input int budget);
        int start;
        int g;
        int b;
        int pick;
        int choice;
        int cells;
        bit must_restart;
        send_idle_pct = idle_pct;
        stall_pct = stall_level;
        start = cells_sent;
        must_restart = 1'b1;
        while (cells_sent - start < budget)
        begin
            choice = $urandom_range(0, 3);
            if (cells_sent == start)
                choice = 3;
            else if (must_restart && choice == 0)
                choice = 3;
            if (choice != 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    g = $urandom_range(3, 8);
                else if (pick < 95)
                    g = $urandom_range(9, 16);
                else
                    g = $urandom_range(17, 28);
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    b = 0;
                else if (pick < 90)
                    b = $urandom_range(1, (g - 1) / 2);
                else
                    b = $urandom_range((g + 1) / 2, 511);
                settle();
                if (choice != 2)
                    write_register(REG_GRID_SIZE, CFG_DATA_W'(g));
                if (choice != 1)
                    write_register(REG_BORDER_WIDTH, CFG_DATA_W'(b));
            end
            cells = eff_grid() * eff_grid();
            must_restart = 1'b0;
            // cut some frames short
            if ($urandom_range(0, 99) < 12 && cells > 1)
            begin
                cells = $urandom_range(1, cells - 1);
                must_restart = 1'b1;
            end
            stream_cells(cells);
        end
        settle();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_default_grid();
        test_smallest_grid();
        test_no_interior();
        test_restart_midframe();
        test_result_backpressure();
        test_random_frames(0, 0, 110);
        test_random_frames(47, 0, 110);
        test_random_frames(0, 47, 110);
        test_random_frames(18, 18, 110);
        settle();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
